/* hdl/xfsmt_pkg.sv */
`default_nettype none

package xfsmt_pkg;

   localparam int WORD_W = 64;
   localparam int HALF_W = 32;
   localparam int LOW_W  = 31;

   localparam int unsigned MT_N  = 312;
   localparam int unsigned MT_M  = 156;
   localparam int          MT_AW = $clog2(MT_N);

   localparam logic [MT_AW-1:0] MT_LAST = MT_AW'(MT_N - 1);
   localparam logic [MT_AW-1:0] MT_OFF  = MT_AW'(MT_M);
   localparam logic [MT_AW-1:0] MT_WRAP = MT_AW'(MT_N - MT_M);

   localparam logic [WORD_W-1:0] MT_MATRIX    = 64'hB502_6F5A_A966_19E9;
   localparam logic [WORD_W-1:0] MT_INIT_MULT = 64'h5851_F42D_4C95_7F2D;
   localparam logic [HALF_W-1:0] MT_MULT_LO   = MT_INIT_MULT[HALF_W-1:0];
   localparam logic [HALF_W-1:0] MT_MULT_HI   = MT_INIT_MULT[WORD_W-1:HALF_W];
   localparam logic [WORD_W-1:0] KEY_SALT     = 64'hCEAC_3B5A_8678_37AC;
   localparam logic [WORD_W-1:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam int ACT_W = 2;
   localparam logic [ACT_W-1:0] ACT_ABSORB = 2'd0;
   localparam logic [ACT_W-1:0] ACT_SEED   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_DRAW   = 2'd2;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 2'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED_LO,
      ST_SEED_HI1,
      ST_SEED_HI2,
      ST_SEED_WR,
      ST_DRAW_CUR,
      ST_DRAW_NXT,
      ST_DRAW_MID,
      ST_DRAW_OUT
   } state_type;

   // Recompute one state word from its old value, its successor and the word M ahead.
   function automatic logic [WORD_W-1:0] mt_twist(input logic [WORD_W-1:0] cur,
                                                  input logic [LOW_W-1:0]  nxt_low,
                                                  input logic [WORD_W-1:0] mid);
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] v;
      y = {cur[WORD_W-1:LOW_W], nxt_low};
      v = mid ^ {1'b0, y[WORD_W-1:1]};
      if (y[0]) begin
         v = v ^ MT_MATRIX;
      end
      return v;
   endfunction

   function automatic logic [WORD_W-1:0] mt_temper(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] y;
      y = w;
      y = y ^ ((y >> 29) & 64'h5555_5555_5555_5555);
      y = y ^ ((y << 17) & 64'h71D6_7FFF_EDA6_0000);
      y = y ^ ((y << 37) & 64'hFFF7_EEE0_0000_0000);
      y = y ^ (y >> 43);
      return y;
   endfunction

endpackage

`default_nettype wire

/* hdl/xor_fold_seeded_mt64_keystream_unit.sv */
// Timing: an absorb only updates the fold; a draw before seeding shows its result in the
//   next cycle; a seeded draw makes three reads of the one state RAM port, then tempers.
// Throughput: absorb 1 item per cycle while busy is low; a seeded draw and a seed keep
//   busy high until done; the shared 32x32 multiplier builds the state words in a seed.
// Reset (synchronous): fold all ones, keys zero, generator unseeded, no result pending.
// The receiver cannot stall: each result shows on rsp_valid for one cycle.
`default_nettype none

module xor_fold_seeded_mt64_keystream_unit
   import xfsmt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // command channel
   input  wire logic                 start,
   output      logic                 busy,
   input  wire logic [ACT_W-1:0]     req_action,
   input  wire logic [WORD_W-1:0]    req_data_word,
   // result channel
   output      logic                 rsp_valid,
   output      logic [WORD_W-1:0]    rsp_value,
   output      logic                 rsp_seeded,
   // register writes
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_wr_data
);

   // control state
   state_type         state_ff,   state_in;
   logic [MT_AW-1:0]  pos_ff,     pos_in;     // next word to twist and emit
   logic [MT_AW-1:0]  idx_ff,     idx_in;     // seeding word index
   logic              seeded_ff,  seeded_in;
   logic [WORD_W-1:0] fold_ff,    fold_in;
   logic [WORD_W-1:0] key_low_ff, key_low_in;
   logic [WORD_W-1:0] key_high_ff, key_high_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [WORD_W-1:0] prev_ff,  prev_in;      // last seeded word
   logic [WORD_W-1:0] lo_ff,    lo_in;        // low partial product
   logic [HALF_W-1:0] hi_ff,    hi_in;        // cross terms, upper half only
   logic [WORD_W-1:0] cur_ff,   cur_in;
   logic [LOW_W-1:0]  nxt_ff,   nxt_in;
   logic [WORD_W-1:0] twist_ff, twist_in;
   logic [WORD_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_seeded_ff, rsp_seeded_in;

   // state RAM port
   logic              mem_wr_en;
   logic [MT_AW-1:0]  mem_wr_addr;
   logic [WORD_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [MT_AW-1:0]  mem_rd_addr;
   logic [WORD_W-1:0] mem_rd_data;

   // shared multiplier and helpers
   logic [HALF_W-1:0] mul_a;
   logic [HALF_W-1:0] mul_b;
   logic [WORD_W-1:0] mul_p;
   logic [WORD_W-1:0] seed_x;
   logic [WORD_W-1:0] seed_word;
   logic [WORD_W-1:0] seed_value;
   logic [WORD_W-1:0] twist_word;
   logic [MT_AW-1:0]  pos_next;
   logic [MT_AW-1:0]  pos_mid;
   logic              accept;

   xfsmt_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MT_N)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Seeding recurrence: x = p ^ (p >> 62); word = MULT * x + i, low 64 bits only,
   // built from three 32x32 products in states SEED_LO, SEED_HI1 and SEED_HI2.
   assign seed_x     = prev_ff ^ (prev_ff >> 62);
   assign mul_p      = WORD_W'(mul_a) * WORD_W'(mul_b);
   assign seed_word  = {lo_ff[WORD_W-1:HALF_W] + hi_ff, lo_ff[HALF_W-1:0]}
                       + WORD_W'(idx_ff);
   assign seed_value = key_low_ff ^ key_high_ff ^ KEY_SALT ^ fold_ff;

   // Twist one word on demand: words below pos are already new, the rest still old,
   // which matches a whole-table regeneration done ahead of the draw.
   assign twist_word = mt_twist(cur_ff, nxt_ff, mem_rd_data);
   assign pos_next   = (pos_ff == MT_LAST) ? '0 : pos_ff + MT_AW'(1);
   assign pos_mid    = (pos_ff >= MT_WRAP) ? pos_ff - MT_WRAP : pos_ff + MT_OFF;

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      seeded_in     = seeded_ff;
      fold_in       = fold_ff;
      key_low_in    = key_low_ff;
      key_high_in   = key_high_ff;
      rsp_valid_in  = 1'b0;
      prev_in       = prev_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      cur_in        = cur_ff;
      nxt_in        = nxt_ff;
      twist_in      = twist_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_seeded_in = rsp_seeded_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = pos_ff;
      mem_wr_data   = twist_word;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = pos_ff;
      mul_a         = seed_x[HALF_W-1:0];
      mul_b         = MT_MULT_LO;

      // register writes; indexes beyond the list drop
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KEY_LOW:  key_low_in  = csr_wr_data;
            CSR_KEY_HIGH: key_high_in = csr_wr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_ABSORB: begin
                     fold_in = fold_ff ^ req_data_word;
                  end
                  ACT_SEED: begin
                     // word 0 is the seed itself; fold restarts at all ones
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = '0;
                     mem_wr_data = seed_value;
                     prev_in     = seed_value;
                     idx_in      = MT_AW'(1);
                     fold_in     = ALL_ONES;
                     state_in    = ST_SEED_LO;
                  end
                  ACT_DRAW: begin
                     if (seeded_ff) begin
                        mem_rd_en = 1'b1;
                        state_in  = ST_DRAW_CUR;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = '0;
                        rsp_seeded_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SEED_LO: begin
            lo_in    = mul_p;
            state_in = ST_SEED_HI1;
         end
         ST_SEED_HI1: begin
            mul_a    = seed_x[WORD_W-1:HALF_W];
            hi_in    = mul_p[HALF_W-1:0];
            state_in = ST_SEED_HI2;
         end
         ST_SEED_HI2: begin
            mul_b    = MT_MULT_HI;
            hi_in    = hi_ff + mul_p[HALF_W-1:0];
            state_in = ST_SEED_WR;
         end
         ST_SEED_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = idx_ff;
            mem_wr_data = seed_word;
            prev_in     = seed_word;
            if (idx_ff == MT_LAST) begin
               pos_in    = '0;
               seeded_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               idx_in   = idx_ff + MT_AW'(1);
               state_in = ST_SEED_LO;
            end
         end
         ST_DRAW_CUR: begin
            cur_in      = mem_rd_data;
            mem_rd_en   = 1'b1;
            mem_rd_addr = pos_next;
            state_in    = ST_DRAW_NXT;
         end
         ST_DRAW_NXT: begin
            nxt_in      = mem_rd_data[LOW_W-1:0];
            mem_rd_en   = 1'b1;
            mem_rd_addr = pos_mid;
            state_in    = ST_DRAW_MID;
         end
         ST_DRAW_MID: begin
            // write back the twisted word in place
            mem_wr_en = 1'b1;
            twist_in  = twist_word;
            state_in  = ST_DRAW_OUT;
         end
         ST_DRAW_OUT: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = mt_temper(twist_ff);
            rsp_seeded_in = 1'b1;
            pos_in        = pos_next;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         idx_ff       <= '0;
         seeded_ff    <= 1'b0;
         fold_ff      <= ALL_ONES;
         key_low_ff   <= '0;
         key_high_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         seeded_ff    <= seeded_in;
         fold_ff      <= fold_in;
         key_low_ff   <= key_low_in;
         key_high_ff  <= key_high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      prev_ff       <= prev_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      cur_ff        <= cur_in;
      nxt_ff        <= nxt_in;
      twist_ff      <= twist_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_seeded_ff <= rsp_seeded_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_seeded = rsp_seeded_ff;

`ifndef SYNTHESIS
   a_seeded_rsp_from_draw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_seeded |-> $past(state_ff) == ST_DRAW_OUT)
      else $error("seeded transfer without a finished draw");

   a_unseeded_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_seeded |-> rsp_value == '0)
      else $error("unseeded transfer carries a nonzero value");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= MT_LAST)
      else $error("draw position past the table");

   a_ram_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> state_ff == ST_SEED_WR || state_ff == ST_DRAW_MID
                    || (state_ff == ST_IDLE && start))
      else $error("state RAM written outside seed or twist");

   a_seed_sets_flag: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEED_WR && idx_ff == MT_LAST |=> seeded_ff && state_ff == ST_IDLE)
      else $error("seeding finished without setting the flag");
`endif

endmodule

`default_nettype wire

/* hdl/xfsmt_ram.sv */
`default_nettype none

module xfsmt_ram #(
   parameter  int WIDTH  = 64,
   parameter  int DEPTH  = 312,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* tb/tb_xor_fold_seeded_mt64_keystream_unit.sv */
`timescale 1ns / 1ps

module tb_xor_fold_seeded_mt64_keystream_unit;
   import xfsmt_pkg::*;

   // Action code 3 has no package name; the block must ignore it.
   localparam logic [ACT_W-1:0]     ACT_UNUSED  = 2'd3;
   // Indexes past the register list; writes to them must not disturb the keys.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam logic [WORD_W-1:0] TW_UPPER = 64'hFFFF_FFFF_8000_0000;
   localparam logic [WORD_W-1:0] TW_LOWER = 64'h0000_0000_7FFF_FFFF;

   localparam int RANDOM_ITEMS  = 1950;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 12;
   localparam int N_DIRECTED    = 21;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic              seeded;
   } keystream_rsp_type;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [WORD_W-1:0] data;
      logic              fixed;
      keystream_rsp_type want;
   } stim_row_type;

   // Directed table. Only draws made before any seed carry a typed result;
   // every other row is checked against the predictor.
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{ACT_DRAW,   64'h0,                   1'b1, '{64'h0, 1'b0}}, // draw while cold
      '{ACT_UNUSED, ALL_ONES,                1'b0, '{64'h0, 1'b0}}, // unused code
      '{ACT_DRAW,   ALL_ONES,                1'b1, '{64'h0, 1'b0}}, // still cold
      '{ACT_ABSORB, 64'h0,                   1'b0, '{64'h0, 1'b0}},
      '{ACT_ABSORB, ALL_ONES,                1'b0, '{64'h0, 1'b0}},
      '{ACT_ABSORB, 64'h8000_0000_0000_0001, 1'b0, '{64'h0, 1'b0}},
      '{ACT_ABSORB, 64'h0123_4567_89AB_CDEF, 1'b0, '{64'h0, 1'b0}},
      '{ACT_SEED,   64'hDEAD_BEEF_DEAD_BEEF, 1'b0, '{64'h0, 1'b0}}, // zero keys
      '{ACT_DRAW,   64'h0,                   1'b0, '{64'h0, 1'b0}},
      '{ACT_DRAW,   ALL_ONES,                1'b0, '{64'h0, 1'b0}},
      '{ACT_DRAW,   64'h0,                   1'b0, '{64'h0, 1'b0}},
      '{ACT_UNUSED, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, '{64'h0, 1'b0}},
      '{ACT_DRAW,   64'h0,                   1'b0, '{64'h0, 1'b0}},
      '{ACT_ABSORB, 64'hFFFF_FFFF_0000_0000, 1'b0, '{64'h0, 1'b0}}, // fold only
      '{ACT_DRAW,   64'h0,                   1'b0, '{64'h0, 1'b0}},
      '{ACT_SEED,   64'h0,                   1'b0, '{64'h0, 1'b0}}, // reseed
      '{ACT_DRAW,   64'h0,                   1'b0, '{64'h0, 1'b0}},
      '{ACT_DRAW,   64'h0,                   1'b0, '{64'h0, 1'b0}},
      '{ACT_SEED,   ALL_ONES,                1'b0, '{64'h0, 1'b0}}, // fold back at ones
      '{ACT_DRAW,   64'h0,                   1'b0, '{64'h0, 1'b0}},
      '{ACT_DRAW,   ALL_ONES,                1'b0, '{64'h0, 1'b0}}
   };

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [ACT_W-1:0]     req_action;
   logic [WORD_W-1:0]    req_data_word;
   logic                 rsp_valid;
   logic [WORD_W-1:0]    rsp_value;
   logic                 rsp_seeded;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_wr_data;

   // Predictor state: keys, fold and a private copy of the twister.
   logic [WORD_W-1:0] mdl_key_low;
   logic [WORD_W-1:0] mdl_key_high;
   logic [WORD_W-1:0] mdl_fold;
   logic [WORD_W-1:0] mdl_words [MT_N];
   int unsigned       mdl_pos;
   logic              mdl_seeded;

   // Draw results still owed by the block, oldest first.
   keystream_rsp_type expected_words [$];
   keystream_rsp_type oldest;

   int error_count   = 0;
   int items_sent    = 0;
   int n_absorb      = 0;
   int n_seed        = 0;
   int n_draw_warm   = 0;
   int n_draw_cold   = 0;
   int n_ignored     = 0;
   int n_csr_writes  = 0;
   int n_checked     = 0;

   xor_fold_seeded_mt64_keystream_unit dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_action    (req_action),
      .req_data_word (req_data_word),
      .rsp_valid     (rsp_valid),
      .rsp_value     (rsp_value),
      .rsp_seeded    (rsp_seeded),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Safety net: a hung handshake or a lost result ends here.
   initial begin
      #3_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   // Fill the twister from one seed word with the usual linear recurrence.
   function automatic void mt_seed_words(input logic [WORD_W-1:0] s);
      logic [WORD_W-1:0] p;
      mdl_words[0] = s;
      for (int i = 1; i < MT_N; i++) begin
         p = mdl_words[i-1];
         mdl_words[i] = MT_INIT_MULT * (p ^ (p >> 62)) + WORD_W'(i);
      end
      mdl_pos = MT_N;
   endfunction

   // Twist the whole table in place; later words see already-twisted ones.
   function automatic void mt_refill();
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] v;
      for (int i = 0; i < MT_N; i++) begin
         y = (mdl_words[i] & TW_UPPER) | (mdl_words[(i + 1) % MT_N] & TW_LOWER);
         v = mdl_words[(i + MT_M) % MT_N] ^ (y >> 1);
         if (y[0]) begin
            v = v ^ MT_MATRIX;
         end
         mdl_words[i] = v;
      end
      mdl_pos = 0;
   endfunction

   function automatic logic [WORD_W-1:0] mt_next_word();
      logic [WORD_W-1:0] y;
      if (mdl_pos >= MT_N) begin
         mt_refill();
      end
      y = mdl_words[mdl_pos];
      mdl_pos++;
      y = y ^ ((y >> 29) & 64'h5555_5555_5555_5555);
      y = y ^ ((y << 17) & 64'h71D6_7FFF_EDA6_0000);
      y = y ^ ((y << 37) & 64'hFFF7_EEE0_0000_0000);
      y = y ^ (y >> 43);
      return y;
   endfunction

   // Advance the predictor by one accepted command; report the draw result if any.
   function automatic void keystream_step(input logic [ACT_W-1:0] act,
                                          input logic [WORD_W-1:0] data,
                                          output bit has_rsp,
                                          output keystream_rsp_type rsp);
      has_rsp = 1'b0;
      rsp     = '0;
      case (act)
         ACT_ABSORB: begin
            mdl_fold = mdl_fold ^ data;
            n_absorb++;
         end
         ACT_SEED: begin
            mt_seed_words(mdl_key_low ^ mdl_key_high ^ KEY_SALT ^ mdl_fold);
            mdl_fold   = ALL_ONES;
            mdl_seeded = 1'b1;
            n_seed++;
         end
         ACT_DRAW: begin
            has_rsp = 1'b1;
            if (mdl_seeded) begin
               rsp.value  = mt_next_word();
               rsp.seeded = 1'b1;
               n_draw_warm++;
            end else begin
               n_draw_cold++;
            end
         end
         default: begin
            n_ignored++;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // Favor corner words: zero, all ones, one hot, one cold; else fully random.
   function automatic logic [WORD_W-1:0] pick_word();
      logic [WORD_W-1:0] hot;
      hot = 64'd1 << $urandom_range(0, 63);
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return ALL_ONES;
         2:       return hot;
         3:       return ~hot;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   function automatic int gap_draw(input bit quiet);
      return quiet ? 0 : $urandom_range(0, 11);
   endfunction

   // Wait out the idle gap, present the command, hold it until the block takes
   // it, then run the predictor. start is only touched once per falling edge.
   task automatic send_item(input logic [ACT_W-1:0]  act,
                            input logic [WORD_W-1:0] data,
                            input int                gap,
                            input bit                fixed,
                            input keystream_rsp_type fixed_rsp);
      bit                has_rsp;
      keystream_rsp_type rsp;
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start         <= 1'b1;
      req_action    <= act;
      req_data_word <= data;
      // busy read at the edge is its pre-edge value, so this is the accept test
      do @(posedge clock); while (busy !== 1'b0);
      keystream_step(act, data, has_rsp, rsp);
      if (has_rsp) begin
         expected_words.push_back(fixed ? fixed_rsp : rsp);
      end
      if (act != ACT_UNUSED) begin
         items_sent++;
      end
   endtask

   // Drop start and wait until every owed result is in and busy is low.
   // With settle set, also cover the tail of a seed that has no result.
   task automatic wait_drained(input bit settle);
      int cycles;
      cycles = 0;
      @(negedge clock);
      start <= 1'b0;
      while ((expected_words.size() != 0 || busy !== 1'b0) && cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      if (settle) begin
         repeat (SETTLE_CYCLES) @(posedge clock);
      end
   endtask

   // One register write per falling edge; the caller lowers the enable.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      case (idx)
         CSR_KEY_LOW:  mdl_key_low  = data;
         CSR_KEY_HIGH: mdl_key_high = data;
         default: ;
      endcase
      n_csr_writes++;
   endtask

   // ---------------------------------------------------------------- result checker

   // Results cannot be held off: check each strobe against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid !== 1'b0) begin
         if (expected_words.size() == 0) begin
            $error("result transfer with nothing expected: value %h seeded %b",
                   rsp_value, rsp_seeded);
            error_count++;
         end else begin
            oldest = expected_words.pop_front();
            if (rsp_value !== oldest.value) begin
               $error("value mismatch: expected %h, actual %h", oldest.value, rsp_value);
               error_count++;
            end
            if (rsp_seeded !== oldest.seeded) begin
               $error("seeded mismatch: expected %b, actual %b", oldest.seeded, rsp_seeded);
               error_count++;
            end
            n_checked++;
         end
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      bit                quiet;
      bit                first;
      int                n_abs;
      int                n_draw;
      int                pick;
      int                target;
      logic [WORD_W-1:0] key_lo;
      logic [WORD_W-1:0] key_hi;

      // Hold every input at a known value from time zero.
      reset         = 1'b1;
      start         = 1'b0;
      req_action    = ACT_ABSORB;
      req_data_word = '0;
      csr_wr_en     = 1'b0;
      csr_index     = CSR_KEY_LOW;
      csr_wr_data   = '0;

      mdl_key_low  = '0;
      mdl_key_high = '0;
      mdl_fold     = ALL_ONES;
      mdl_pos      = MT_N;
      mdl_seeded   = 1'b0;
      for (int i = 0; i < MT_N; i++) begin
         mdl_words[i] = '0;
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part runs on the reset keys of zero.
      foreach (directed_rows[r]) begin
         send_item(directed_rows[r].action, directed_rows[r].data, $urandom_range(0, 11),
                   directed_rows[r].fixed, directed_rows[r].want);
      end

      // Random part: sessions of absorb words, a seed, then a run of draws.
      // Long runs cross the twister refill; a few sessions skip the seed and
      // keep drawing from the old state, and stray absorbs and unused codes
      // are sprinkled among the draws.
      first  = 1'b1;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         if (first || $urandom_range(0, 3) == 0) begin
            // Keys change only with the block idle and nothing owed.
            wait_drained(1'b1);
            if (first) begin
               key_lo = ALL_ONES;
               key_hi = ALL_ONES;
            end else begin
               key_lo = pick_word();
               key_hi = pick_word();
            end
            write_reg(CSR_KEY_LOW, key_lo);
            write_reg(CSR_KEY_HIGH, key_hi);
            if ($urandom_range(0, 2) == 0) begin
               write_reg($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3, pick_word());
            end
            @(negedge clock);
            csr_wr_en <= 1'b0;
         end

         quiet = ($urandom_range(0, 3) == 0);
         n_abs = $urandom_range(0, 4);
         repeat (n_abs) send_item(ACT_ABSORB, pick_word(), gap_draw(quiet), 1'b0, '0);
         if ($urandom_range(0, 7) != 0) begin
            send_item(ACT_SEED, pick_word(), gap_draw(quiet), 1'b0, '0);
         end

         n_draw = ($urandom_range(0, 7) == 0) ? $urandom_range(320, 700)
                                              : $urandom_range(1, 24);
         repeat (n_draw) begin
            pick = $urandom_range(0, 23);
            if (pick == 0) begin
               send_item(ACT_ABSORB, pick_word(), gap_draw(quiet), 1'b0, '0);
            end else if (pick == 1) begin
               send_item(ACT_UNUSED, pick_word(), gap_draw(quiet), 1'b0, '0);
            end else begin
               send_item(ACT_DRAW, pick_word(), gap_draw(quiet), 1'b0, '0);
            end
         end

         // Hold off the sender now and then until every result has come back.
         if (first || $urandom_range(0, 4) == 0) begin
            wait_drained(1'b0);
         end
         first = 1'b0;
      end

      // Drain, let the pipeline settle, then flag anything still owed.
      wait_drained(1'b1);
      if (expected_words.size() != 0) begin
         $error("%0d draw results never arrived", expected_words.size());
         error_count++;
      end

      $display("Covered %0d command transfers: %0d absorbs, %0d seeds, %0d draws (%0d cold).",
               items_sent, n_absorb, n_seed, n_draw_warm + n_draw_cold, n_draw_cold);
      $display("Ignored %0d unused codes, wrote %0d registers, checked %0d results.",
               n_ignored, n_csr_writes, n_checked);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* xor_fold_seeded_mt64_keystream_unit.f */
hdl/xfsmt_pkg.sv
hdl/xfsmt_ram.sv
hdl/xor_fold_seeded_mt64_keystream_unit.sv
tb/tb_xor_fold_seeded_mt64_keystream_unit.sv
